FILE: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that an expression never holds while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/sobel_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sobel package
// Shared constants and types of the Sobel edge magnitude block.
// -----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 12;
  localparam int unsigned PixW     = 8;
  localparam int unsigned SumW     = 22;   // gx^2 + gy^2 never exceeds 2*1020^2
  localparam int unsigned RootW    = 11;
  localparam int unsigned RootSteps = 11;

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

  // Register addresses (byte addresses).
  localparam logic [2:0] AddrWidth  = 3'd0;
  localparam logic [2:0] AddrHeight = 3'd4;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // Controller state machine.
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRead  = 4'b0010,
    StRoot  = 4'b0100,
    StOut   = 4'b1000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the accepted item and look up the row stores
    logic shift;     // update stores, window and counters
    logic root_step; // one step of the square root
    logic restart;   // never driven or read; a register write clears counters and window
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ignore;    // early flush, no work
    logic emit;      // the item gives a result
  } dp_status_t;

endpackage

FILE: hw/rtl/sobel_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sobel controller
// Sequences one item at a time through lookup, square root and output.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"
module sobel_ctrl import sobel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic [$clog2(RootSteps+1)-1:0] step_q, step_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        if (status_i.ignore) begin
          state_d = StIdle;
        end else begin
          cmd_o.shift = 1'b1;
          step_d = '0;
          state_d = status_i.emit ? StRoot : StIdle;
        end
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == ($clog2(RootSteps+1))'(RootSteps - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  `ASSERT_CLK(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
      (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
  `ASSERT_NEVER(a_excl, clk_i, rst_ni, in_ready_o && out_valid_o, "overlap")

endmodule

FILE: hw/rtl/sobel_dp.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sobel datapath
// Row stores, 3x3 window, frame counters, gradients and square root unit.
// -----------------------------------------------------------------------------
module sobel_dp import sobel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic               command_i,
  input  logic [PixW-1:0]    pixel_i,
  input  logic [WidthW-1:0]  width_i,
  input  logic [HeightW-1:0] height_i,
  input  logic               cfg_restart_i,
  output logic [PixW-1:0]    edge_res_o,
  output logic               frame_last_o
);

  // Row store memories.
  logic [PixW-1:0] older_mem [MaxWidth];
  logic [PixW-1:0] newer_mem [MaxWidth];
  logic [PixW-1:0] a_q, b_q, v_q;
  logic            cmd_q;

  logic [PixW-1:0] win_q [3][3];
  // The input row runs up to height+1 while the flush items drain the frame.
  logic [HeightW:0]   in_row_q;
  logic [HeightW-1:0] out_row_q;
  logic [WidthW-1:0]  in_col_q, out_col_q;
  logic [ColW-1:0]    col;

  logic past;
  assign past = (in_row_q >= {1'b0, height_i});
  assign col  = (in_col_q >= WidthW'(MaxWidth)) ? ColW'(MaxWidth - 1) : in_col_q[ColW-1:0];

  // Item latch and memory read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q <= command_i;
      v_q   <= past ? '0 : pixel_i;
      a_q   <= older_mem[col];
      b_q   <= newer_mem[col];
    end
  end

  // Memory write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      older_mem[col] <= b_q;
      newer_mem[col] <= v_q;
    end
  end

  assign status_o.ignore = !past && (cmd_q == CmdFlush);
  assign status_o.emit   = (in_row_q >= (HeightW+1)'(2)) ||
                           (in_row_q == (HeightW+1)'(1) && in_col_q >= WidthW'(1));

  // Border masks for the output position.
  logic top, bottom, left, right, last;
  assign top    = out_row_q != '0;
  assign bottom = ({1'b0, out_row_q} + 13'd1) < {1'b0, height_i};
  assign left   = out_col_q != '0;
  assign right  = ({1'b0, out_col_q} + 12'd1) < {1'b0, width_i};
  assign last   = !bottom && !right;

  // Window after this shift, masked.
  logic [PixW-1:0] w [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i][0] = win_q[i][1];
      w[i][1] = win_q[i][2];
    end
    w[0][2] = a_q;
    w[1][2] = b_q;
    w[2][2] = v_q;
    for (int i = 0; i < 3; i++) begin
      if (!left)  w[i][0] = '0;
      if (!right) w[i][2] = '0;
    end
    for (int j = 0; j < 3; j++) begin
      if (!top)    w[0][j] = '0;
      if (!bottom) w[2][j] = '0;
    end
  end

  logic signed [11:0] gx, gy;
  assign gx = $signed({4'd0, w[0][0]}) + $signed({3'd0, w[1][0], 1'b0}) +
              $signed({4'd0, w[2][0]}) - $signed({4'd0, w[0][2]}) -
              $signed({3'd0, w[1][2], 1'b0}) - $signed({4'd0, w[2][2]});
  assign gy = $signed({4'd0, w[0][0]}) + $signed({3'd0, w[0][1], 1'b0}) +
              $signed({4'd0, w[0][2]}) - $signed({4'd0, w[2][0]}) -
              $signed({3'd0, w[2][1], 1'b0}) - $signed({4'd0, w[2][2]});

  logic signed [11:0] gx_q, gy_q;
  logic               last_q;

  // Window, counters and gradient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '{default: '0};
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      last_q    <= 1'b0;
    end else if (cfg_restart_i) begin
      win_q     <= '{default: '0};
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= a_q;
      win_q[1][2] <= b_q;
      win_q[2][2] <= v_q;
      if (({1'b0, in_col_q} + 12'd1) >= {1'b0, width_i}) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + 1'b1;
      end else begin
        in_col_q <= in_col_q + 1'b1;
      end
      if (status_o.emit) begin
        last_q <= last;
        if (last) begin
          win_q     <= '{default: '0};
          in_row_q  <= '0;
          in_col_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
        end else if (({1'b0, out_col_q} + 12'd1) >= {1'b0, width_i}) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      gx_q <= gx;
      gy_q <= gy;
    end
  end

  // Square root, one result bit per step (restoring method).
  logic [SumW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [SumW-1:0]  sq_d;
  logic [11:0]      ax, ay;
  logic [SumW-1:0]  trial;
  logic [$clog2(RootSteps)-1:0] bitpos_q;
  logic [SumW-1:0] rem_first;

  assign ax = gx_q[11] ? 12'(-gx_q) : 12'(gx_q);
  assign ay = gy_q[11] ? 12'(-gy_q) : 12'(gy_q);
  assign sq_d = SumW'(ax) * SumW'(ax) + SumW'(ay) * SumW'(ay);
  assign rem_first = sq_d;

  logic [SumW-1:0] rem_cur;
  logic [RootW-1:0] root_cur;
  logic first_q;
  assign rem_cur  = first_q ? rem_first : rem_q;
  assign root_cur = first_q ? '0 : root_q;
  assign trial    = SumW'({root_cur, 2'b01}) << {bitpos_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 1'b0;
      bitpos_q <= '0;
    end else if (cmd_i.shift) begin
      first_q  <= 1'b1;
      bitpos_q <= ($clog2(RootSteps))'(RootSteps - 1);
    end else if (cmd_i.root_step) begin
      first_q  <= 1'b0;
      bitpos_q <= bitpos_q - 1'b1;
    end
  end

  // Each step compares (4*root+1)<<(2*k) with the remainder.
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_step) begin
      if (rem_cur >= trial) begin
        rem_q  <= rem_cur - trial;
        root_q <= {root_cur[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_cur;
        root_q <= {root_cur[RootW-2:0], 1'b0};
      end
    end
  end

  assign edge_res_o   = (root_q > RootW'(255)) ? 8'hFF : root_q[PixW-1:0];
  assign frame_last_o = last_q;

endmodule

FILE: hw/rtl/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Sobel edge magnitude
// 3x3 Sobel gradient magnitude over a raster pixel stream.
// -----------------------------------------------------------------------------
// One item at a time: it passes the idle and read states, the bit-serial
// square root unit when it gives a result, and the output state until the
// result is taken. Row stores are read on acceptance and, unless it is an early
// flush, written next. Send width+1 flush items after the last pixel of a frame.
module sobel_edge_magnitude import sobel_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] pixel
  input  logic        s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] edge_res
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic               restart;
  logic               wr;
  ctrl_cmd_t          cmd;
  dp_status_t         status;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Configuration registers with width and height clamping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (wr) begin
      case (paddr)
        AddrWidth: begin
          if (pwdata[WidthW-1:0] == '0) width_q <= WidthW'(1);
          else if (pwdata[WidthW-1:0] > WidthW'(MaxWidth)) width_q <= WidthW'(MaxWidth);
          else width_q <= pwdata[WidthW-1:0];
        end
        AddrHeight: begin
          height_q <= (pwdata[HeightW-1:0] == '0) ? HeightW'(1) : pwdata[HeightW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign restart = wr && (paddr == AddrWidth || paddr == AddrHeight);

  // Register read back.
  always_comb begin
    case (paddr)
      AddrWidth:  prdata = 32'(width_q);
      AddrHeight: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  sobel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sobel_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .command_i     (s_axis_tuser),
    .pixel_i       (s_axis_tdata),
    .width_i       (width_q),
    .height_i      (height_q),
    .cfg_restart_i (restart),
    .edge_res_o    (m_axis_tdata),
    .frame_last_o  (m_axis_tlast)
  );

endmodule
